// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the queue RTL; all are clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/aqr_pkg.sv =====
// Shared types, codes and constants for the linear queue with prefix reverse.
package aqr_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned STAT_W        = 2;
  localparam int unsigned OCC_W         = 5;

  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REV = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
  } aqr_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [OCC_W-1:0]        occupancy;
  } aqr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI,
    S_REPLY
  } aqr_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic deq_pop;
    logic rd_lo;
    logic rd_hi;
    logic wr_lo;
    logic wr_hi;
    logic load;
  } aqr_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              no_pairs;
    logic              last_pair;
  } aqr_stat_t;

endpackage

// ===== hw/rtl/array_queue_with_prefix_reverse.sv =====
// Linear array queue of DEPTH 32-bit words taking enqueue, dequeue and
// reverse-first-k command words, one result word per command. A command word
// passes through the execute and reply states; a successful dequeue adds a pop
// state, and a reverse with k clamped to the occupancy adds a read-low,
// read-high, write-low, write-high sequence for every swapped pair, since each
// pair costs two reads and two writes on the single read port and single write
// port of the slot memory. The result word is loaded into the result register
// from the reply state. A new command word is accepted only after the previous
// result has gone into the result register; that register lets the next command
// run while an earlier result waits to be taken, and the block stalls before
// loading its own result until it is.
module array_queue_with_prefix_reverse #(
  parameter int unsigned DEPTH = aqr_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aqr_pkg::aqr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aqr_pkg::aqr_out_t out_data
);
  import aqr_pkg::*;

  aqr_cmd_t  cmd;
  aqr_stat_t stat;

  aqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aqr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/aqr_ctrl.sv =====
// Controller state machine: sequences each command word through the datapath.
`include "assert_macros.svh"

module aqr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  aqr_pkg::aqr_stat_t stat,
  output aqr_pkg::aqr_cmd_t  cmd
);
  import aqr_pkg::*;

  aqr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (stat.kind)
          KIND_DEQ: state_next = stat.empty ? S_REPLY : S_DEQ;
          KIND_REV: state_next = (stat.empty || stat.no_pairs) ? S_REPLY : S_RD_LO;
          default:  state_next = S_REPLY;
        endcase
      end
      S_DEQ:   state_next = S_REPLY;
      S_RD_LO: state_next = S_RD_HI;
      S_RD_HI: state_next = S_WR_LO;
      S_WR_LO: state_next = S_WR_HI;
      S_WR_HI: state_next = stat.last_pair ? S_REPLY : S_RD_LO;
      S_REPLY: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // Hold off the input while reset is asserted.
        in_ready  = !rst;
        cmd.latch = in_valid && !rst;
      end
      S_EXEC:  cmd.exec    = 1'b1;
      S_DEQ:   cmd.deq_pop = 1'b1;
      S_RD_LO: cmd.rd_lo   = 1'b1;
      S_RD_HI: cmd.rd_hi   = 1'b1;
      S_WR_LO: cmd.wr_lo   = 1'b1;
      S_WR_HI: cmd.wr_hi   = 1'b1;
      S_REPLY: cmd.load    = !out_valid || out_ready;
      default: cmd         = '0;
    endcase
  end

  // Output word stays valid until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_load_free, cmd.load, !out_valid || out_ready, "load over pending word")
  `ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state == S_EXEC, "accepted word not executed")
  `ASSERT_NEXT(a_valid_src, !out_valid && !cmd.load, !out_valid, "out_valid rose without a load")

endmodule

// ===== hw/rtl/aqr_dpath.sv =====
// Datapath: slot memory, head/tail pointers, swap registers and the result register.
`include "assert_macros.svh"

module aqr_dpath #(
  parameter int unsigned DEPTH = aqr_pkg::DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  aqr_pkg::aqr_in_t   in_data,
  input  aqr_pkg::aqr_cmd_t  cmd,
  output aqr_pkg::aqr_stat_t stat,
  output aqr_pkg::aqr_out_t  out_data
);
  import aqr_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (OW > CNT_W) ? OW : CNT_W;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [VAL_W-1:0] slots [DEPTH];
  logic [VAL_W-1:0] rdata;

  logic [IW-1:0] head, tail;
  logic          is_empty;

  logic [KIND_W-1:0] cmd_kind;
  logic [VAL_W-1:0]  cmd_value;
  logic [CNT_W-1:0]  cmd_count;

  logic [IW-1:0]    lo, hi;
  logic [OW-1:0]    rem;
  logic [VAL_W-1:0] temp;

  logic [STAT_W-1:0] res_status;
  logic [VAL_W-1:0]  res_removed;

  logic [OW-1:0] occ;
  logic [KW-1:0] k_wide;
  logic [OW-1:0] k_occ;
  logic [OW-1:0] pairs;
  logic          enq_ok;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata;

  assign occ    = is_empty ? '0 : OW'(tail) - OW'(head) + OW'(1);
  assign k_wide = (KW'(cmd_count) < KW'(occ)) ? KW'(cmd_count) : KW'(occ);
  assign k_occ  = OW'(k_wide);
  assign pairs  = k_occ >> 1;
  assign enq_ok = is_empty || (tail != LAST);

  assign stat.kind      = cmd_kind;
  assign stat.empty     = is_empty;
  assign stat.no_pairs  = (pairs == '0);
  assign stat.last_pair = (rem == OW'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = cmd_value;
    if (cmd.exec && cmd_kind == KIND_ENQ && enq_ok) begin
      mem_we    = 1'b1;
      mem_waddr = is_empty ? '0 : tail + IW'(1);
    end else if (cmd.wr_lo) begin
      mem_we    = 1'b1;
      mem_waddr = lo;
      mem_wdata = rdata;
    end else if (cmd.wr_hi) begin
      mem_we    = 1'b1;
      mem_waddr = hi;
      mem_wdata = temp;
    end
  end

  assign mem_re    = (cmd.exec && cmd_kind == KIND_DEQ) || cmd.rd_lo || cmd.rd_hi;
  assign mem_raddr = cmd.rd_lo ? lo : (cmd.rd_hi ? hi : head);

  always_ff @(posedge clk) begin
    if (mem_we) slots[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= slots[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
    end else if (cmd.exec && cmd_kind == KIND_ENQ && enq_ok) begin
      if (is_empty) begin
        head     <= '0;
        tail     <= '0;
        is_empty <= 1'b0;
      end else begin
        tail <= tail + IW'(1);
      end
    end else if (cmd.deq_pop) begin
      // Drop the last element: both pointers return to slot zero.
      if (head == tail) begin
        head     <= '0;
        tail     <= '0;
        is_empty <= 1'b1;
      end else begin
        head <= head + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_kind  <= in_data.kind;
      cmd_value <= in_data.value;
      cmd_count <= in_data.count;
    end
    if (cmd.exec) begin
      res_removed <= '0;
      case (cmd_kind)
        KIND_ENQ: res_status <= enq_ok ? ST_OK : ST_OVERFLOW;
        KIND_DEQ: res_status <= is_empty ? ST_UNDERFLOW : ST_OK;
        KIND_REV: begin
          res_status <= is_empty ? ST_EMPTY : ST_OK;
          lo  <= head;
          hi  <= head + IW'(k_occ) - IW'(1);
          rem <= pairs;
        end
        default: res_status <= ST_OK;
      endcase
    end
    if (cmd.deq_pop) res_removed <= rdata;
    // Hold the low element while the high one is read.
    if (cmd.rd_hi) temp <= rdata;
    if (cmd.wr_hi) begin
      lo  <= lo + IW'(1);
      hi  <= hi - IW'(1);
      rem <= rem - OW'(1);
    end
    if (cmd.load) begin
      out_data.status        <= res_status;
      out_data.removed_value <= res_removed;
      out_data.occupancy     <= OCC_W'(occ);
    end
  end

  `ASSERT_IMPLIES(a_empty_ptrs, is_empty, head == '0 && tail == '0, "empty with moved pointers")
  `ASSERT_HOLDS(a_ptr_order, head <= tail, "head passed tail")
  `ASSERT_IMPLIES(a_swap_order, cmd.rd_lo, lo < hi && rem != '0, "swap pair out of order")

endmodule

// ===== bench/aqr_checker.sv =====
// Checker for the linear queue: tracks the queue contents and compares each result word.
`timescale 1ns / 100ps

module aqr_checker #(
  parameter int unsigned DEPTH = aqr_pkg::DEFAULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  aqr_pkg::aqr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  aqr_pkg::aqr_out_t out_data,
  output int                mismatches,
  output int                owed
);
  import aqr_pkg::*;

  logic signed [VAL_W-1:0] slot_mem [DEPTH];
  int unsigned             head_ptr;
  int unsigned             tail_ptr;
  bit                      q_empty;
  aqr_out_t                expected_results [$];

  initial begin
    mismatches = 0;
    owed = 0;
  end

  function automatic logic [OCC_W-1:0] held_words();
    return q_empty ? '0 : OCC_W'(tail_ptr - head_ptr + 1);
  endfunction

  // Apply one command word to the tracked queue and return the result word it yields.
  function automatic aqr_out_t run_command(aqr_in_t c);
    aqr_out_t                r;
    int unsigned             k;
    int unsigned             i;
    logic signed [VAL_W-1:0] t;
    r = '0;
    r.status = ST_OK;
    case (c.kind)
      KIND_ENQ: begin
        if (q_empty) begin
          head_ptr = 0;
          tail_ptr = 0;
          slot_mem[0] = c.value;
          q_empty = 1'b0;
        end else if (tail_ptr >= DEPTH - 1) begin
          // linear queue: freed front slots are not reused
          r.status = ST_OVERFLOW;
        end else begin
          tail_ptr++;
          slot_mem[tail_ptr] = c.value;
        end
      end
      KIND_DEQ: begin
        if (q_empty) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.removed_value = slot_mem[head_ptr];
          if (head_ptr == tail_ptr) begin
            head_ptr = 0;
            tail_ptr = 0;
            q_empty = 1'b1;
          end else begin
            head_ptr++;
          end
        end
      end
      KIND_REV: begin
        if (q_empty) begin
          r.status = ST_EMPTY;
        end else begin
          k = 32'(c.count);
          if (k > 32'(held_words())) k = 32'(held_words());
          for (i = 0; i < k / 2; i++) begin
            t = slot_mem[head_ptr + i];
            slot_mem[head_ptr + i] = slot_mem[head_ptr + k - 1 - i];
            slot_mem[head_ptr + k - 1 - i] = t;
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = held_words();
    return r;
  endfunction

  task automatic report_error(string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    aqr_out_t want;
    if (rst) begin
      head_ptr = 0;
      tail_ptr = 0;
      q_empty = 1'b1;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) expected_results.push_back(run_command(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result word status=%0d removed=%0d occ=%0d",
                                 out_data.status, out_data.removed_value, out_data.occupancy));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_error($sformatf("status got %0d want %0d",
                                   out_data.status, want.status));
          if (out_data.removed_value !== want.removed_value)
            report_error($sformatf("removed_value got %0d want %0d",
                                   out_data.removed_value, want.removed_value));
          if (out_data.occupancy !== want.occupancy)
            report_error($sformatf("occupancy got %0d want %0d",
                                   out_data.occupancy, want.occupancy));
        end
      end
    end
    owed = expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the linear queue: clock, reset, command stimulus and final verdict.
`timescale 1ns / 100ps

module tb_top;
  import aqr_pkg::*;

  localparam int unsigned       DEPTH       = DEFAULT_DEPTH;
  localparam int                NUM_WORDS   = 950;
  localparam int                LONG_HOLD   = 400;
  localparam int                HOLD_AFTER  = 400;
  localparam int                DRAIN_AT    = 600;
  localparam int                SETTLE      = 64;
  localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  aqr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  aqr_out_t out_data;
  int       mismatch_count;
  int       results_owed;
  int       words_sent;
  bit       hold_done;

  array_queue_with_prefix_reverse #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  aqr_checker #(.DEPTH(DEPTH)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatch_count),
    .owed      (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic aqr_in_t make_cmd(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value,
                                       logic [CNT_W-1:0] count);
    aqr_in_t c;
    c.kind = kind;
    c.value = value;
    c.count = count;
    return c;
  endfunction

  // mode 0 leans to filling, 1 to draining, 2 is balanced
  function automatic aqr_in_t random_cmd(int unsigned mode);
    int unsigned       roll;
    int unsigned       enq_pct;
    int unsigned       deq_pct;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(99);
    enq_pct = (mode == 0) ? 65 : (mode == 1) ? 15 : 40;
    deq_pct = (mode == 0) ? 10 : (mode == 1) ? 60 : 35;
    if (roll < enq_pct)                     kind = KIND_ENQ;
    else if (roll < enq_pct + deq_pct)      kind = KIND_DEQ;
    else if (roll < 97)                     kind = KIND_REV;
    else                                    kind = KIND_NOP;
    return make_cmd(kind, $urandom, CNT_W'($urandom_range(0, 16)));
  endfunction

  task automatic send_word(aqr_in_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= make_cmd(KIND_W'($urandom), $urandom, CNT_W'($urandom));
    end
  endtask

  // hold the input until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_owed == 0);
  endtask

  // receiver: own stall pattern, plus one long hold-off to back up the block
  initial begin
    int unsigned mode;
    int unsigned len;
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(8, 64);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int          burst_left;
    int unsigned mode;
    int          mode_left;
    int          i;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    words_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty-queue cases
    send_word(make_cmd(KIND_DEQ, 32'h1234_5678, 5'd3));
    send_word(make_cmd(KIND_REV, 32'h0, 5'd5));
    send_word(make_cmd(KIND_NOP, 32'hFFFF_FFFF, 5'd31));
    // fill to the last slot with extreme values first
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0: send_word(make_cmd(KIND_ENQ, 32'h8000_0000, 5'd0));
        1: send_word(make_cmd(KIND_ENQ, 32'h7FFF_FFFF, 5'd0));
        2: send_word(make_cmd(KIND_ENQ, 32'h0, 5'd0));
        3: send_word(make_cmd(KIND_ENQ, 32'hFFFF_FFFF, 5'd0));
        default: send_word(make_cmd(KIND_ENQ, $urandom, 5'd0));
      endcase
    end
    send_word(make_cmd(KIND_ENQ, 32'hDEAD_BEEF, 5'd0));
    send_word(make_cmd(KIND_REV, 32'h0, 5'd16));
    send_word(make_cmd(KIND_REV, 32'h0, 5'd0));
    send_word(make_cmd(KIND_REV, 32'h0, 5'd1));
    send_word(make_cmd(KIND_DEQ, 32'h0, 5'd0));
    // front slot is free but tail is at the end: still overflow
    send_word(make_cmd(KIND_ENQ, 32'h5555_AAAA, 5'd0));
    send_word(make_cmd(KIND_REV, 32'h0, 5'd16));
    send_word(make_cmd(KIND_NOP, 32'hAAAA_5555, 5'd16));
    wait_drained();

    burst_left = 0;
    mode_left = 0;
    mode = 0;
    while (words_sent < NUM_WORDS) begin
      if (words_sent == DRAIN_AT) wait_drained();
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 40);
      end
      if (burst_left == 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      send_word(random_cmd(mode));
      burst_left--;
      mode_left--;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_owed == 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/aqr_pkg.sv
hw/rtl/aqr_ctrl.sv
hw/rtl/aqr_dpath.sv
hw/rtl/array_queue_with_prefix_reverse.sv
bench/aqr_checker.sv
bench/tb_top.sv
